@@ design/skst_pkg.sv @@
// Package: shared codes and types for the sorted key slot table.
package skst_pkg;

  typedef enum logic [2:0] {
    MODE_FIND    = 3'd0,
    MODE_GET     = 3'd1,
    MODE_RM_KEY  = 3'd2,
    MODE_RM_POS  = 3'd3,
    MODE_REPLACE = 3'd4,
    MODE_RD_POS  = 3'd5
  } mode_e;

  typedef enum logic [2:0] {
    POL_EXIT  = 3'd0,
    POL_NULL  = 3'd1,
    POL_DUMMY = 3'd2,
    POL_ALL   = 3'd3,
    POL_NEVER = 3'd4
  } policy_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_NF    = 2'd1,
    ST_FULL  = 2'd2,
    ST_EXIT  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SRCH,
    S_EXEC
  } state_e;

  typedef enum logic [2:0] {
    CO_HOLD,
    CO_LEFT,
    CO_RIGHT,
    CO_LOAD_A,
    CO_LOAD_B
  } cell_op_e;

  // compare flags of one cell against the two request keys
  typedef struct packed {
    logic lt_a;
    logic eq_a;
    logic lt_b;
    logic eq_b;
  } cmp_t;

  localparam logic [0:0] ADDR_MISS_POLICY = 1'b0;

endpackage

@@ design/skst_if.sv @@
// Interfaces: request and result channels of the sorted key slot table.
interface skst_in_if #(
  parameter int KEY_BITS = 32
);
  logic                valid;
  logic                ready;
  logic [2:0]          mode;
  logic [KEY_BITS-1:0] key;
  logic [KEY_BITS-1:0] second_key;
  logic [5:0]          position;
  logic                create_ok;

  modport source (output valid, mode, key, second_key, position, create_ok, input ready);
  modport sink   (input valid, mode, key, second_key, position, create_ok, output ready);
endinterface

interface skst_out_if;
  logic        valid;
  logic        ready;
  logic        hit;
  logic [5:0]  slot;
  logic [5:0]  sorted_index;
  logic [31:0] key_out;
  logic        is_dummy;
  logic        created;
  logic [1:0]  status;
  logic [6:0]  entry_total;

  modport source (output valid, hit, slot, sorted_index, key_out, is_dummy, created, status,
                  entry_total, input ready);
  modport sink   (input valid, hit, slot, sorted_index, key_out, is_dummy, created, status,
                  entry_total, output ready);
endinterface

@@ design/skst_cell.sv @@
// Cell: one sorted position (key, slot, dummy mark) with its key comparators.
module skst_cell #(
  parameter int KEY_BITS = 32,
  parameter int IW       = 6
) (
  input  logic                clk_i,
  input  skst_pkg::cell_op_e  op_i,
  input  logic                valid_i,
  input  logic [KEY_BITS-1:0] key_a_i,
  input  logic [KEY_BITS-1:0] key_b_i,
  input  logic [KEY_BITS-1:0] left_key_i,
  input  logic [IW-1:0]       left_slot_i,
  input  logic                left_dummy_i,
  input  logic [KEY_BITS-1:0] right_key_i,
  input  logic [IW-1:0]       right_slot_i,
  input  logic                right_dummy_i,
  input  logic [KEY_BITS-1:0] inj_a_key_i,
  input  logic [IW-1:0]       inj_a_slot_i,
  input  logic                inj_a_dummy_i,
  input  logic [KEY_BITS-1:0] inj_b_key_i,
  input  logic [IW-1:0]       inj_b_slot_i,
  input  logic                inj_b_dummy_i,
  output logic [KEY_BITS-1:0] key_o,
  output logic [IW-1:0]       slot_o,
  output logic                dummy_o,
  output skst_pkg::cmp_t      cmp_o
);

  logic [KEY_BITS-1:0] key_q, key_d;
  logic [IW-1:0]       slot_q, slot_d;
  logic                dummy_q, dummy_d;

  always_comb begin
    key_d   = key_q;
    slot_d  = slot_q;
    dummy_d = dummy_q;
    case (op_i)
      skst_pkg::CO_LEFT: begin
        key_d = left_key_i; slot_d = left_slot_i; dummy_d = left_dummy_i;
      end
      skst_pkg::CO_RIGHT: begin
        key_d = right_key_i; slot_d = right_slot_i; dummy_d = right_dummy_i;
      end
      skst_pkg::CO_LOAD_A: begin
        key_d = inj_a_key_i; slot_d = inj_a_slot_i; dummy_d = inj_a_dummy_i;
      end
      skst_pkg::CO_LOAD_B: begin
        key_d = inj_b_key_i; slot_d = inj_b_slot_i; dummy_d = inj_b_dummy_i;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    slot_q  <= slot_d;
    dummy_q <= dummy_d;
  end

  assign key_o   = key_q;
  assign slot_o  = slot_q;
  assign dummy_o = dummy_q;

  assign cmp_o.lt_a = valid_i && (key_q < key_a_i);
  assign cmp_o.eq_a = valid_i && (key_q == key_a_i);
  assign cmp_o.lt_b = valid_i && (key_q < key_b_i);
  assign cmp_o.eq_b = valid_i && (key_q == key_b_i);

endmodule

@@ design/sorted_key_slot_table.sv @@
// Top level: sorted key slot table built as a chain of position cells.
//
//  channel | dir | handshake       | word
//  --------+-----+-----------------+-----------------------------------------------
//  in_if   | in  | valid/ready     | mode, key, second_key, position, create_ok
//  out_if  | out | valid/ready     | hit, slot, sorted_index, key_out, is_dummy,
//          |     |                 | created, status, entry_total
//  apb     | in  | psel/penable    | miss_policy at address 0
//
// Each request passes through capture, a parallel compare in every cell
// (the lower bound is the first cell not below the key), then an update
// in which the cells shift by one toward or away from a position.
// One request is in flight at a time; ready is high only in the idle state.
// A finished word waits in the output register; the update cycle stalls
// while that register is still full. Reset empties the table at once.
module sorted_key_slot_table #(
  parameter int CAPACITY = 64,
  parameter int KEY_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  skst_in_if.sink     in_if,
  skst_out_if.source  out_if,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [0:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  // config register
  logic [2:0] policy_q;
  assign pready = 1'b1;
  assign prdata = (paddr == skst_pkg::ADDR_MISS_POLICY) ? {29'd0, policy_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q <= 3'd0;
    end else if (psel && penable && pwrite && paddr == skst_pkg::ADDR_MISS_POLICY) begin
      policy_q <= pwdata[2:0];
    end
  end

  // sequencer
  skst_pkg::state_e state_q, state_d;
  logic out_free;
  logic exec_fire;

  assign out_free  = !out_if.valid || out_if.ready;
  assign exec_fire = (state_q == skst_pkg::S_EXEC) && out_free;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      skst_pkg::S_IDLE: if (in_if.valid) state_d = skst_pkg::S_SRCH;
      skst_pkg::S_SRCH: state_d = skst_pkg::S_EXEC;
      skst_pkg::S_EXEC: if (out_free) state_d = skst_pkg::S_IDLE;
      default:          state_d = skst_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_if.ready = (state_q == skst_pkg::S_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= skst_pkg::S_IDLE;
    else         state_q <= state_d;
  end

  // captured request
  logic [2:0]          mode_q;
  logic [KEY_BITS-1:0] k1_q, k2_q;
  logic [5:0]          pos_in_q;
  logic                cok_q;

  always_ff @(posedge clk_i) begin
    if (in_if.valid && in_if.ready) begin
      mode_q   <= in_if.mode;
      k1_q     <= in_if.key;
      k2_q     <= in_if.second_key;
      pos_in_q <= in_if.position;
      cok_q    <= in_if.create_ok;
    end
  end

  // table state outside the cells
  logic [CW-1:0]       count_q, count_d;
  logic [CAPACITY-1:0] free_q, free_d;

  // cell chain
  skst_pkg::cell_op_e  cop   [CAPACITY];
  logic [KEY_BITS-1:0] ckey  [CAPACITY];
  logic [IW-1:0]       cslot [CAPACITY];
  logic                cdum  [CAPACITY];
  skst_pkg::cmp_t      ccmp  [CAPACITY];

  logic [KEY_BITS-1:0] inj_a_key, inj_b_key;
  logic [IW-1:0]       inj_a_slot, inj_b_slot;
  logic                inj_a_dum, inj_b_dum;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    localparam int L = (g == 0) ? 0 : g - 1;
    localparam int R = (g == CAPACITY - 1) ? g : g + 1;
    skst_cell #(.KEY_BITS(KEY_BITS), .IW(IW)) u_cell (
      .clk_i         (clk_i),
      .op_i          (cop[g]),
      .valid_i       (CW'(g) < count_q),
      .key_a_i       (k1_q),
      .key_b_i       (k2_q),
      .left_key_i    (ckey[L]),
      .left_slot_i   (cslot[L]),
      .left_dummy_i  (cdum[L]),
      .right_key_i   (ckey[R]),
      .right_slot_i  (cslot[R]),
      .right_dummy_i (cdum[R]),
      .inj_a_key_i   (inj_a_key),
      .inj_a_slot_i  (inj_a_slot),
      .inj_a_dummy_i (inj_a_dum),
      .inj_b_key_i   (inj_b_key),
      .inj_b_slot_i  (inj_b_slot),
      .inj_b_dummy_i (inj_b_dum),
      .key_o         (ckey[g]),
      .slot_o        (cslot[g]),
      .dummy_o       (cdum[g]),
      .cmp_o         (ccmp[g])
    );
  end

  // search: lower bound is the first cell not below the key
  logic [CW-1:0]       posa_s, posb_s;
  logic                fa_s, fb_s, pv_s;
  logic [IW-1:0]       sa_s, sb_s, sp_s;
  logic                da_s, db_s, dp_s;
  logic [KEY_BITS-1:0] kp_s;

  always_comb begin
    posa_s = count_q;
    posb_s = count_q;
    fa_s = 1'b0; fb_s = 1'b0;
    sa_s = '0; sb_s = '0; sp_s = '0;
    da_s = 1'b0; db_s = 1'b0; dp_s = 1'b0;
    kp_s = '0;
    pv_s = 32'(pos_in_q) < 32'(count_q);
    for (int i = 0; i < CAPACITY; i++) begin
      if (!ccmp[i].lt_a && (i == 0 || ccmp[(i == 0) ? 0 : i - 1].lt_a) && CW'(i) < count_q)
        posa_s = CW'(i);
      if (!ccmp[i].lt_b && (i == 0 || ccmp[(i == 0) ? 0 : i - 1].lt_b) && CW'(i) < count_q)
        posb_s = CW'(i);
      if (ccmp[i].eq_a) begin
        fa_s = 1'b1; sa_s = sa_s | cslot[i]; da_s = da_s | cdum[i];
      end
      if (ccmp[i].eq_b) begin
        fb_s = 1'b1; sb_s = sb_s | cslot[i]; db_s = db_s | cdum[i];
      end
      if (i == 32'(pos_in_q)) begin
        sp_s = cslot[i]; dp_s = cdum[i]; kp_s = ckey[i];
      end
    end
  end

  logic [CW-1:0]       posa_q, posb_q;
  logic                fa_q, fb_q, pv_q;
  logic [IW-1:0]       sa_q, sb_q, sp_q;
  logic                da_q, db_q, dp_q;
  logic [KEY_BITS-1:0] kp_q;

  always_ff @(posedge clk_i) begin
    if (state_q == skst_pkg::S_SRCH) begin
      posa_q <= posa_s; posb_q <= posb_s;
      fa_q <= fa_s; fb_q <= fb_s; pv_q <= pv_s;
      sa_q <= sa_s; sb_q <= sb_s; sp_q <= sp_s;
      da_q <= da_s; db_q <= db_s; dp_q <= dp_s;
      kp_q <= kp_s;
    end
  end

  // lowest free slot
  logic [IW-1:0] free_slot;
  always_comb begin
    free_slot = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (free_q[i]) free_slot = IW'(i);
    end
  end

  // update and result
  logic                r_hit, r_dum, r_cre;
  logic [IW-1:0]       r_slot;
  logic [CW-1:0]       r_idx;
  logic [KEY_BITS-1:0] r_key;
  skst_pkg::status_e   r_st;
  logic                sh_en, sh_left, la_en, lb_en;
  logic [CW-1:0]       sh_lo, sh_hi, la_idx, lb_idx, tgt;
  logic [2:0]          pol;
  logic                do_ins, ins_dum;

  always_comb begin
    r_hit = 1'b0; r_dum = 1'b0; r_cre = 1'b0;
    r_slot = '0; r_idx = '0; r_key = '0;
    r_st = skst_pkg::ST_NF;
    sh_en = 1'b0; sh_left = 1'b0; la_en = 1'b0; lb_en = 1'b0;
    sh_lo = '0; sh_hi = '0; la_idx = '0; lb_idx = '0; tgt = '0;
    inj_a_key = k1_q; inj_a_slot = sa_q; inj_a_dum = da_q;
    inj_b_key = k2_q; inj_b_slot = sb_q; inj_b_dum = db_q;
    count_d = count_q;
    free_d = free_q;
    do_ins = 1'b0;
    ins_dum = 1'b0;
    pol = (policy_q > skst_pkg::POL_NEVER) ? skst_pkg::POL_NULL : policy_q;
    case (mode_q)
      skst_pkg::MODE_FIND, skst_pkg::MODE_RM_KEY: begin
        r_idx = posa_q;
        if (fa_q) begin
          r_hit = 1'b1; r_st = skst_pkg::ST_OK;
          r_slot = sa_q; r_key = k1_q; r_dum = da_q;
          if (mode_q == skst_pkg::MODE_RM_KEY) begin
            sh_en = 1'b1; sh_lo = posa_q; sh_hi = count_q - CW'(1);
            free_d[sa_q] = 1'b1; count_d = count_q - CW'(1);
          end
        end
      end
      skst_pkg::MODE_GET: begin
        r_idx = posa_q;
        if (fa_q) begin
          r_hit = 1'b1; r_st = skst_pkg::ST_OK;
          r_slot = sa_q; r_key = k1_q; r_dum = da_q;
        end else if (pol == skst_pkg::POL_NEVER) begin
          r_st = skst_pkg::ST_NF;
        end else if (32'(count_q) >= CAPACITY) begin
          r_st = skst_pkg::ST_FULL;
        end else if (pol == skst_pkg::POL_ALL || cok_q || pol == skst_pkg::POL_DUMMY) begin
          do_ins  = 1'b1;
          ins_dum = (pol == skst_pkg::POL_ALL) || !cok_q;
        end else begin
          r_st = (pol == skst_pkg::POL_EXIT) ? skst_pkg::ST_EXIT : skst_pkg::ST_NF;
        end
        if (do_ins) begin
          r_cre = 1'b1; r_st = skst_pkg::ST_OK;
          r_slot = free_slot; r_key = k1_q; r_dum = ins_dum;
          inj_a_slot = free_slot; inj_a_dum = ins_dum;
          la_en = 1'b1; la_idx = posa_q;
          sh_en = 1'b1; sh_left = 1'b1; sh_lo = posa_q + CW'(1); sh_hi = count_q;
          free_d[free_slot] = 1'b0; count_d = count_q + CW'(1);
        end
      end
      skst_pkg::MODE_RM_POS, skst_pkg::MODE_RD_POS: begin
        if (pv_q) begin
          r_hit = 1'b1; r_st = skst_pkg::ST_OK;
          r_slot = sp_q; r_key = kp_q; r_dum = dp_q; r_idx = CW'(pos_in_q);
          if (mode_q == skst_pkg::MODE_RM_POS) begin
            sh_en = 1'b1; sh_lo = CW'(pos_in_q); sh_hi = count_q - CW'(1);
            free_d[sp_q] = 1'b1; count_d = count_q - CW'(1);
          end
        end
      end
      skst_pkg::MODE_REPLACE: begin
        if (fa_q && fb_q) begin
          // both keys held: positions keep their keys and trade slots
          r_hit = 1'b1; r_st = skst_pkg::ST_OK;
          r_idx = posb_q; r_slot = sa_q; r_key = k2_q; r_dum = da_q;
          if (posa_q != posb_q) begin
            inj_a_slot = sb_q; inj_a_dum = db_q;
            inj_b_slot = sa_q; inj_b_dum = da_q;
            la_en = 1'b1; la_idx = posa_q;
            lb_en = 1'b1; lb_idx = posb_q;
          end
        end else if (fa_q || fb_q) begin
          // rename one entry and move it to its new place
          r_hit = 1'b1; r_st = skst_pkg::ST_OK;
          if (fa_q) begin
            tgt = (posb_q > posa_q) ? posb_q - CW'(1) : posb_q;
            sh_lo = posa_q;
            inj_a_key = k2_q; inj_a_slot = sa_q; inj_a_dum = da_q;
          end else begin
            tgt = (posa_q > posb_q) ? posa_q - CW'(1) : posa_q;
            sh_lo = posb_q;
            inj_a_key = k1_q; inj_a_slot = sb_q; inj_a_dum = db_q;
          end
          r_idx = tgt; r_slot = inj_a_slot; r_key = inj_a_key; r_dum = inj_a_dum;
          la_en = 1'b1; la_idx = tgt;
          if (sh_lo < tgt) begin
            sh_en = 1'b1; sh_hi = tgt - CW'(1);
          end else if (tgt < sh_lo) begin
            sh_en = 1'b1; sh_left = 1'b1; sh_hi = sh_lo; sh_lo = tgt + CW'(1);
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      cop[i] = skst_pkg::CO_HOLD;
      if (exec_fire) begin
        if (la_en && CW'(i) == la_idx)
          cop[i] = skst_pkg::CO_LOAD_A;
        else if (lb_en && CW'(i) == lb_idx)
          cop[i] = skst_pkg::CO_LOAD_B;
        else if (sh_en && CW'(i) >= sh_lo && CW'(i) <= sh_hi)
          cop[i] = sh_left ? skst_pkg::CO_LEFT : skst_pkg::CO_RIGHT;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      free_q  <= '1;
    end else if (exec_fire) begin
      count_q <= count_d;
      free_q  <= free_d;
    end
  end

  // output register
  logic ov_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)        ov_q <= 1'b0;
    else if (exec_fire) ov_q <= 1'b1;
    else if (out_if.ready) ov_q <= 1'b0;
  end

  logic                o_hit, o_dum, o_cre;
  logic [5:0]          o_slot, o_idx;
  logic [31:0]         o_key;
  logic [1:0]          o_st;
  logic [6:0]          o_tot;

  always_ff @(posedge clk_i) begin
    if (exec_fire) begin
      o_hit  <= r_hit;
      o_slot <= 6'(r_slot);
      o_idx  <= 6'(r_idx);
      o_key  <= 32'(r_key);
      o_dum  <= r_dum;
      o_cre  <= r_cre;
      o_st   <= r_st;
      o_tot  <= 7'(count_d);
    end
  end

  assign out_if.valid        = ov_q;
  assign out_if.hit          = o_hit;
  assign out_if.slot         = o_slot;
  assign out_if.sorted_index = o_idx;
  assign out_if.key_out      = o_key;
  assign out_if.is_dummy     = o_dum;
  assign out_if.created      = o_cre;
  assign out_if.status       = o_st;
  assign out_if.entry_total  = o_tot;

endmodule

@@ design/skst_checker.sv @@
// Checker: port-level properties of the sorted key slot table, bound to the top.
module skst_checker #(
  parameter int CAPACITY = 64
) (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       hit,
  input logic       created,
  input logic [1:0] status,
  input logic [6:0] entry_total
);

  // one request at a time
  a_one_inflight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !in_ready) else $error("ready while busy");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(entry_total))
    else $error("stalled word changed");

  a_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> 32'(entry_total) <= CAPACITY) else $error("entry total over capacity");

  a_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && status == skst_pkg::ST_OK |-> hit || created)
    else $error("ok without hit or create");

  a_created: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && created |-> status == skst_pkg::ST_OK && !hit)
    else $error("created with bad status");

endmodule

bind sorted_key_slot_table skst_checker #(.CAPACITY(CAPACITY)) u_skst_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid    (in_if.valid),
  .in_ready    (in_if.ready),
  .out_valid   (out_if.valid),
  .out_ready   (out_if.ready),
  .hit         (out_if.hit),
  .created     (out_if.created),
  .status      (out_if.status),
  .entry_total (out_if.entry_total)
);

@@ tb/tb_sorted_key_slot_table.sv @@
// Testbench: directed and random requests against the sorted key slot table, self-checking.
module tb_sorted_key_slot_table;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAP = 64;

  // one result word as the table reports it
  typedef struct packed {
    logic        hit;
    logic [5:0]  slot;
    logic [5:0]  sorted_index;
    logic [31:0] key_out;
    logic        is_dummy;
    logic        created;
    logic [1:0]  status;
    logic [6:0]  entry_total;
  } answer_t;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [0:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  skst_in_if #(.KEY_BITS(32)) in_if ();
  skst_out_if                 out_if ();

  sorted_key_slot_table #(.CAPACITY(CAP), .KEY_BITS(32)) u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_if   (in_if),
    .out_if  (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Shadow copy of the table: key order, per-slot key, dummy mark and free flag.
  logic [5:0]  shadow_order [CAP];
  logic [31:0] shadow_key   [CAP];
  logic        shadow_dummy [CAP];
  logic        shadow_free  [CAP];
  int          shadow_count;
  logic [2:0]  shadow_policy;

  answer_t     pending_answers[$];
  int          fail_count;
  int          word_count;
  int          hit_count;
  int          create_count;
  int          full_count;

  // receiver shaping: a long hold-off is requested by a test, counted below
  bit          hold_req;
  bit          steady_ready;
  logic [31:0] key_pool [48];

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("[sorted_key_slot_table] ERROR");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Predictor: one request against the shadow table.
  // --------------------------------------------------------------------------
  function automatic bit lookup_key(input logic [31:0] k, output int pos);
    int lo;
    int hi;
    int mid;
    lo = 0;
    hi = shadow_count;
    while (lo < hi) begin
      mid = (lo + hi) / 2;
      if (k == shadow_key[shadow_order[mid]]) begin
        pos = mid;
        return 1'b1;
      end
      if (k < shadow_key[shadow_order[mid]]) hi = mid;
      else lo = mid + 1;
    end
    pos = lo;
    return 1'b0;
  endfunction

  function automatic void shift_entry(input int from, input int to);
    logic [5:0] s;
    s = shadow_order[from];
    if (from < to) begin
      for (int i = from; i < to; i++) shadow_order[i] = shadow_order[i+1];
    end else begin
      for (int i = from; i > to; i--) shadow_order[i] = shadow_order[i-1];
    end
    shadow_order[to] = s;
  endfunction

  function automatic void drop_entry(input int pos);
    shadow_free[shadow_order[pos]] = 1'b1;
    shadow_count--;
    for (int i = pos; i < shadow_count; i++) shadow_order[i] = shadow_order[i+1];
  endfunction

  function automatic void insert_entry(input int pos, input logic [31:0] k, input logic d);
    int s;
    s = 0;
    while (s < CAP && !shadow_free[s]) s++;
    s = s % CAP;
    shadow_free[s]  = 1'b0;
    shadow_key[s]   = k;
    shadow_dummy[s] = d;
    for (int i = shadow_count; i > pos; i--) shadow_order[i] = shadow_order[i-1];
    shadow_order[pos] = s[5:0];
    shadow_count++;
  endfunction

  function automatic answer_t apply_request(input logic [2:0] mode, input logic [31:0] k1,
                                            input logic [31:0] k2, input logic [5:0] position,
                                            input logic create_ok);
    answer_t    a;
    int         pos;
    int         pos2;
    int         idx;
    bit         fs;
    bit         fd;
    bit         report;
    logic [2:0] pol;
    logic [5:0] sa;
    logic [5:0] sb;
    logic [31:0] t;
    a = '0;
    a.status = skst_pkg::ST_NF;
    idx = 0;
    report = 1'b0;
    case (mode)
      skst_pkg::MODE_FIND, skst_pkg::MODE_RM_KEY: begin
        if (lookup_key(k1, pos)) begin
          a.hit = 1'b1;
          a.status = skst_pkg::ST_OK;
          a.slot = shadow_order[pos];
          a.key_out = shadow_key[a.slot];
          a.is_dummy = shadow_dummy[a.slot];
          idx = pos;
          if (mode == skst_pkg::MODE_RM_KEY) drop_entry(pos);
        end else begin
          idx = pos;
        end
      end
      skst_pkg::MODE_GET: begin
        pol = (shadow_policy > skst_pkg::POL_NEVER) ? skst_pkg::POL_NULL : shadow_policy;
        if (lookup_key(k1, pos)) begin
          a.hit = 1'b1;
          a.status = skst_pkg::ST_OK;
          report = 1'b1;
        end else if (pol == skst_pkg::POL_NEVER) begin
          a.status = skst_pkg::ST_NF;
        end else if (shadow_count >= CAP) begin
          a.status = skst_pkg::ST_FULL;
        end else if (pol == skst_pkg::POL_ALL || create_ok || pol == skst_pkg::POL_DUMMY) begin
          insert_entry(pos, k1, (pol == skst_pkg::POL_ALL) || !create_ok);
          a.created = 1'b1;
          a.status = skst_pkg::ST_OK;
          report = 1'b1;
        end else begin
          a.status = (pol == skst_pkg::POL_EXIT) ? skst_pkg::ST_EXIT : skst_pkg::ST_NF;
        end
        idx = pos;
        if (report) begin
          a.slot = shadow_order[idx];
          a.key_out = shadow_key[a.slot];
          a.is_dummy = shadow_dummy[a.slot];
        end
      end
      skst_pkg::MODE_RM_POS, skst_pkg::MODE_RD_POS: begin
        if (position < shadow_count) begin
          a.hit = 1'b1;
          a.status = skst_pkg::ST_OK;
          a.slot = shadow_order[position];
          a.key_out = shadow_key[a.slot];
          a.is_dummy = shadow_dummy[a.slot];
          idx = position;
          if (mode == skst_pkg::MODE_RM_POS) drop_entry(position);
        end
      end
      skst_pkg::MODE_REPLACE: begin
        fs = lookup_key(k1, pos);
        fd = lookup_key(k2, pos2);
        if (fs || fd) begin
          a.hit = 1'b1;
          a.status = skst_pkg::ST_OK;
          if (fs && fd) begin
            if (pos != pos2) begin
              sa = shadow_order[pos];
              sb = shadow_order[pos2];
              t = shadow_key[sa];
              shadow_key[sa] = shadow_key[sb];
              shadow_key[sb] = t;
              shadow_order[pos]  = sb;
              shadow_order[pos2] = sa;
            end
            idx = pos2;
          end else if (fs) begin
            shadow_key[shadow_order[pos]] = k2;
            if (pos2 > pos) pos2--;
            shift_entry(pos, pos2);
            idx = pos2;
          end else begin
            shadow_key[shadow_order[pos2]] = k1;
            if (pos > pos2) pos--;
            shift_entry(pos2, pos);
            idx = pos;
          end
          a.slot = shadow_order[idx];
          a.key_out = shadow_key[a.slot];
          a.is_dummy = shadow_dummy[a.slot];
        end
      end
      default: ;
    endcase
    a.sorted_index = idx[5:0];
    a.entry_total = shadow_count[6:0];
    return a;
  endfunction

  // --------------------------------------------------------------------------
  // Request side
  // --------------------------------------------------------------------------
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady_ready || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Offers one request word, waits for acceptance, then predicts it.
  task automatic send_request(input logic [2:0] mode, input logic [31:0] k1,
                              input logic [31:0] k2, input logic [5:0] position,
                              input logic create_ok);
    int gap;
    answer_t a;
    in_if.valid      <= 1'b1;
    in_if.mode       <= mode;
    in_if.key        <= k1;
    in_if.second_key <= k2;
    in_if.position   <= position;
    in_if.create_ok  <= create_ok;
    do @(posedge clk_i); while (!in_if.ready);
    a = apply_request(mode, k1, k2, position, create_ok);
    pending_answers.push_back(a);
    gap = pick_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Stops offering, then waits for the table to drain.
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_policy(input logic [2:0] value);
    wait_drained();
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= skst_pkg::ADDR_MISS_POLICY;
    pwdata  <= {29'd0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    shadow_policy = value;
  endtask

  // --------------------------------------------------------------------------
  // Result side: ready shaping and checking
  // --------------------------------------------------------------------------
  int low_left;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      low_left = 0;
    end else if (hold_req) begin
      // long hold-off so the table backs up into its input
      hold_req = 1'b0;
      low_left = 400;
      out_if.ready <= 1'b0;
    end else if (low_left > 0) begin
      low_left--;
      out_if.ready <= 1'b0;
    end else if (steady_ready) begin
      out_if.ready <= 1'b1;
    end else begin
      if ($urandom_range(0, 99) < 30) begin
        low_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 3);
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    answer_t exp_a;
    if (rst_ni && out_if.valid && out_if.ready) begin
      word_count++;
      if (pending_answers.size() == 0) begin
        $error("result word with nothing expected");
        fail_count++;
      end else begin
        exp_a = pending_answers.pop_front();
        if (exp_a.hit) hit_count++;
        if (exp_a.created) create_count++;
        if (exp_a.status == skst_pkg::ST_FULL) full_count++;
        if (out_if.hit !== exp_a.hit) begin
          $error("hit: expected %0d got %0d", exp_a.hit, out_if.hit);
          fail_count++;
        end
        if (out_if.slot !== exp_a.slot) begin
          $error("slot: expected %0d got %0d", exp_a.slot, out_if.slot);
          fail_count++;
        end
        if (out_if.sorted_index !== exp_a.sorted_index) begin
          $error("sorted_index: expected %0d got %0d", exp_a.sorted_index,
                 out_if.sorted_index);
          fail_count++;
        end
        if (out_if.key_out !== exp_a.key_out) begin
          $error("key_out: expected %h got %h", exp_a.key_out, out_if.key_out);
          fail_count++;
        end
        if (out_if.is_dummy !== exp_a.is_dummy) begin
          $error("is_dummy: expected %0d got %0d", exp_a.is_dummy, out_if.is_dummy);
          fail_count++;
        end
        if (out_if.created !== exp_a.created) begin
          $error("created: expected %0d got %0d", exp_a.created, out_if.created);
          fail_count++;
        end
        if (out_if.status !== exp_a.status) begin
          $error("status: expected %0d got %0d", exp_a.status, out_if.status);
          fail_count++;
        end
        if (out_if.entry_total !== exp_a.entry_total) begin
          $error("entry_total: expected %0d got %0d", exp_a.entry_total,
                 out_if.entry_total);
          fail_count++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  function automatic logic [31:0] pick_key();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return key_pool[$urandom_range(0, 47)];
    if (r < 85) return 32'hFFFF_FFFF;
    if (r < 90) return 32'd0;
    return $urandom;
  endfunction

  task automatic refill_pool();
    for (int i = 0; i < 48; i++) key_pool[i] = $urandom;
    key_pool[0] = 32'd0;
    key_pool[1] = 32'hFFFF_FFFF;
    key_pool[2] = 32'd1;
  endtask

  // Edge keys, every mode, out-of-range positions and each replace case.
  task automatic test_directed();
    write_policy(skst_pkg::POL_EXIT);
    send_request(skst_pkg::MODE_FIND, 32'd5, 32'd0, 6'd0, 1'b1);          // empty table
    send_request(skst_pkg::MODE_RD_POS, 32'd0, 32'd0, 6'd0, 1'b1);        // position beyond
    send_request(skst_pkg::MODE_GET, 32'hFFFF_FFFF, 32'd0, 6'd0, 1'b1);
    send_request(skst_pkg::MODE_GET, 32'd0, 32'd0, 6'd0, 1'b1);
    send_request(skst_pkg::MODE_GET, 32'h8000_0000, 32'd0, 6'd0, 1'b0);   // exit error
    send_request(skst_pkg::MODE_GET, 32'd0, 32'd0, 6'd0, 1'b0);           // hit
    send_request(skst_pkg::MODE_GET, 32'h7FFF_FFFF, 32'd0, 6'd0, 1'b1);
    send_request(skst_pkg::MODE_FIND, 32'h7FFF_FFFF, 32'd0, 6'd0, 1'b0);
    send_request(skst_pkg::MODE_FIND, 32'h0000_0003, 32'd0, 6'd0, 1'b0);  // insertion point
    send_request(skst_pkg::MODE_RD_POS, 32'd0, 32'd0, 6'd2, 1'b0);
    send_request(skst_pkg::MODE_RD_POS, 32'd0, 32'd0, 6'd63, 1'b0);
    send_request(skst_pkg::MODE_REPLACE, 32'd0, 32'hFFFF_FFFF, 6'd0, 1'b0);       // swap
    send_request(skst_pkg::MODE_REPLACE, 32'd0, 32'd0, 6'd0, 1'b0);               // same key
    send_request(skst_pkg::MODE_REPLACE, 32'h7FFF_FFFF, 32'h0000_0010, 6'd0, 1'b0);
    send_request(skst_pkg::MODE_REPLACE, 32'hF000_0000, 32'h0000_0010, 6'd0, 1'b0);
    send_request(skst_pkg::MODE_REPLACE, 32'h1234_5678, 32'h8765_4321, 6'd0, 1'b0);
    send_request(3'd6, 32'd0, 32'd0, 6'd0, 1'b1);
    send_request(3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'h3F, 1'b1);
    send_request(skst_pkg::MODE_RM_POS, 32'd0, 32'd0, 6'd63, 1'b0);
    send_request(skst_pkg::MODE_RM_POS, 32'd0, 32'd0, 6'd0, 1'b0);
    send_request(skst_pkg::MODE_RM_KEY, 32'hFFFF_FFFF, 32'd0, 6'd0, 1'b0);
    send_request(skst_pkg::MODE_RM_KEY, 32'hFFFF_FFFF, 32'd0, 6'd0, 1'b0);
  endtask

  // Policy edges: dummy on failure, all dummy, never insert, undefined codes.
  task automatic test_policies();
    write_policy(skst_pkg::POL_DUMMY);
    send_request(skst_pkg::MODE_GET, 32'd100, 32'd0, 6'd0, 1'b0);
    send_request(skst_pkg::MODE_GET, 32'd101, 32'd0, 6'd0, 1'b1);
    write_policy(skst_pkg::POL_ALL);
    send_request(skst_pkg::MODE_GET, 32'd102, 32'd0, 6'd0, 1'b1);
    write_policy(skst_pkg::POL_NEVER);
    send_request(skst_pkg::MODE_GET, 32'd103, 32'd0, 6'd0, 1'b1);
    write_policy(3'd7);
    send_request(skst_pkg::MODE_GET, 32'd104, 32'd0, 6'd0, 1'b0);
    send_request(skst_pkg::MODE_GET, 32'd105, 32'd0, 6'd0, 1'b1);
  endtask

  // Fill to capacity, then misses that would insert must report full.
  task automatic test_full_table();
    write_policy(skst_pkg::POL_ALL);
    for (int i = 0; i < 70; i++) send_request(skst_pkg::MODE_GET, $urandom, 32'd0, 6'd0, 1'b1);
    send_request(skst_pkg::MODE_GET, 32'hFFFF_FFFE, 32'd0, 6'd0, 1'b1);
    send_request(skst_pkg::MODE_RD_POS, 32'd0, 32'd0, 6'd63, 1'b0);
    send_request(skst_pkg::MODE_RM_POS, 32'd0, 32'd0, 6'd63, 1'b0);
    send_request(skst_pkg::MODE_RM_POS, 32'd0, 32'd0, 6'd0, 1'b0);
  endtask

  // Mixed random traffic under one policy, keys mostly from a small pool.
  task automatic test_random_phase(input logic [2:0] policy, input int items);
    int r;
    logic [2:0] mode;
    logic [5:0] position;
    write_policy(policy);
    refill_pool();
    for (int n = 0; n < items; n++) begin
      r = $urandom_range(0, 99);
      if (r < 38) mode = skst_pkg::MODE_GET;
      else if (r < 50) mode = skst_pkg::MODE_FIND;
      else if (r < 60) mode = skst_pkg::MODE_RM_KEY;
      else if (r < 67) mode = skst_pkg::MODE_RM_POS;
      else if (r < 80) mode = skst_pkg::MODE_REPLACE;
      else if (r < 95) mode = skst_pkg::MODE_RD_POS;
      else mode = 3'($urandom_range(6, 7));
      if (shadow_count > 0 && $urandom_range(0, 3) != 0)
        position = 6'($urandom_range(0, shadow_count - 1));
      else
        position = 6'($urandom);
      send_request(mode, pick_key(), pick_key(), position, 1'($urandom));
    end
  endtask

  // Receiver stops for a long stretch while requests keep coming.
  task automatic test_backpressure();
    write_policy(skst_pkg::POL_NULL);
    hold_req = 1'b1;
    for (int i = 0; i < 30; i++)
      send_request(skst_pkg::MODE_GET, pick_key(), 32'd0, 6'd0, 1'($urandom));
  endtask

  initial begin
    rst_ni           = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    in_if.valid      = 1'b0;
    in_if.mode       = skst_pkg::MODE_FIND;
    in_if.key        = '0;
    in_if.second_key = '0;
    in_if.position   = '0;
    in_if.create_ok  = 1'b0;
    fail_count       = 0;
    word_count       = 0;
    hit_count        = 0;
    create_count     = 0;
    full_count       = 0;
    hold_req         = 1'b0;
    steady_ready     = 1'b0;
    shadow_count     = 0;
    shadow_policy    = skst_pkg::POL_EXIT;
    for (int i = 0; i < CAP; i++) begin
      shadow_order[i] = '0;
      shadow_key[i]   = '0;
      shadow_dummy[i] = 1'b0;
      shadow_free[i]  = 1'b1;
    end
    refill_pool();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_policies();
    test_full_table();
    test_backpressure();
    test_random_phase(skst_pkg::POL_EXIT, 90);
    test_random_phase(skst_pkg::POL_NULL, 90);
    steady_ready = 1'b1;           // a stretch with no idling on either side
    test_random_phase(skst_pkg::POL_DUMMY, 90);
    steady_ready = 1'b0;
    test_random_phase(skst_pkg::POL_ALL, 110);
    test_random_phase(skst_pkg::POL_NEVER, 70);
    test_random_phase(3'd5, 60);
    test_random_phase(3'd7, 60);
    test_random_phase(skst_pkg::POL_ALL, 80);

    wait_drained();
    repeat (20) @(posedge clk_i);
    $display("Covered %0d result words: %0d hits, %0d inserts, %0d full-table answers,",
             word_count, hit_count, create_count, full_count);
    $display("all miss policies including undefined codes, and a long output stall.");
    if (fail_count == 0) begin
      $display("[sorted_key_slot_table] OK");
    end else begin
      $display("[sorted_key_slot_table] ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
design/skst_pkg.sv
design/skst_if.sv
design/skst_cell.sv
design/sorted_key_slot_table.sv
design/skst_checker.sv
tb/tb_sorted_key_slot_table.sv
